[rtl/lkvc_pkg.sv]
// Shared types and constants for the LRU key-value cache.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package lkvc_pkg;

  // Widths fixed by the external interface.
  localparam int unsigned KEY_IN_BITS = 16;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned CAP_BITS    = 5;

  // Capacity register value after reset.
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  // Value returned by a get that misses.
  localparam logic signed [VALUE_BITS-1:0] MISS_VALUE = -32'sd1;

  // Command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Operation codes.
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  // Request as it arrives on the input channel.
  typedef struct packed {
    logic                         mode;
    logic [KEY_IN_BITS-1:0]       lookup_key;
    logic signed [VALUE_BITS-1:0] store_value;
  } req_t;

  // Result as it leaves on the output channel.
  typedef struct packed {
    logic                         hit;
    logic signed [VALUE_BITS-1:0] read_value;
  } rsp_t;

  // Decoded command held in the queue.
  typedef struct packed {
    op_e                    op;
    logic [KEY_IN_BITS-1:0] key;
    logic [VALUE_BITS-1:0]  value;
  } cmd_t;

  // Handshake between the queue and the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

`default_nettype wire

[rtl/lru_key_value_cache_top.sv]
// Top level of the LRU key-value cache: front end with command queue and
// back end with tag match and LRU update. Depends on lkvc_pkg, lkvc_front
// and lkvc_back.
//
// Usage:
//   A request (get or put with key and value) is transferred at a rising
//   edge where start is high and busy is low. Requests wait in a two-entry
//   queue. Each request yields exactly one result, shown for one cycle on
//   rsp_o with out_valid_o high; the receiver cannot stall, so every strobe
//   is a completed transfer.
//   The back end takes each command through a lookup state (parallel key
//   compare and value memory read) and an apply state (rank, tag and value
//   update) before it takes the next; the strobe is registered. busy is
//   high while both queue entries are occupied. The capacity register is
//   written through cfg_we_i/cfg_wdata_i; the user must write it only while
//   the block is idle, which the block itself does not enforce. Zero acts
//   as one and values above ENTRIES act as ENTRIES. Reset empties the store
//   and the queue and sets the capacity to 16; the block takes requests in
//   the first cycle after reset.
`default_nettype none

module lru_key_value_cache_top #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire lkvc_pkg::req_t                req_i,
  output logic                               out_valid_o,
  output lkvc_pkg::rsp_t                     rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [lkvc_pkg::CAP_BITS-1:0] cfg_wdata_i
);
  import lkvc_pkg::*;

  cmd_chan_t chan;
  logic      pop;

  // Request intake and command queue.
  lkvc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .chan_o (chan),
    .pop_i  (pop)
  );

  // Lookup, replacement and result generation.
  lkvc_back #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .chan_i      (chan),
    .pop_o       (pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .rsp_o       (rsp_o)
  );

  // Each command passes through a lookup state before its apply state, so strobes never abut.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("result strobes in consecutive cycles");

  // The queue only fills up through an accepted request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted request");

  // A command is taken from the queue only when one is there.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> chan.valid)
    else $error("queue popped while empty");

  // Every command taken from the queue yields a result strobe once its apply state is over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> ##2 out_valid_o)
    else $error("popped command produced no result");

endmodule

`default_nettype wire

[rtl/lkvc_front.sv]
// Front end of the LRU key-value cache: takes requests, decodes them and
// buffers them in a short command queue. Depends on lkvc_pkg.
`default_nettype none

module lkvc_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire lkvc_pkg::req_t    req_i,
  output logic                   busy,
  output lkvc_pkg::cmd_chan_t    chan_o,
  input  wire logic              pop_i
);
  import lkvc_pkg::*;

  cmd_t                 queue_mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] count_q, count_d;
  logic                 push;
  logic                 pop;
  cmd_t                 cmd_in;

  // The block is busy while the queue has no free slot.
  assign busy = (count_q == QCNT_BITS'(QUEUE_DEPTH));
  assign push = start && !busy;
  assign pop  = pop_i && (count_q != '0);

  // Decode the request into a command.
  always_comb begin
    cmd_in.op    = req_i.mode ? OP_PUT : OP_GET;
    cmd_in.key   = req_i.lookup_key;
    cmd_in.value = req_i.store_value;
  end

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage holds payload only, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_mem[wr_ptr_q] <= cmd_in;
    end
  end

  // Head of the queue toward the back end.
  assign chan_o.valid = (count_q != '0);
  assign chan_o.cmd   = queue_mem[rd_ptr_q];

endmodule

`default_nettype wire

[rtl/lkvc_back.sv]
// Back end of the LRU key-value cache: parallel tag match, LRU rank update,
// value memory and result register. Depends on lkvc_pkg.
`default_nettype none

module lkvc_back #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire lkvc_pkg::cmd_chan_t             chan_i,
  output logic                                 pop_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [lkvc_pkg::CAP_BITS-1:0]   cfg_wdata_i,
  output logic                                 out_valid_o,
  output lkvc_pkg::rsp_t                       rsp_o
);
  import lkvc_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned LW = $clog2(ENTRIES + 1);
  localparam int unsigned CW = (LW > CAP_BITS) ? LW : CAP_BITS;

  typedef enum logic [1:0] {
    ST_LOOK  = 2'b01,
    ST_APPLY = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Per-entry tag, valid and recency storage.
  logic [KEY_BITS-1:0]   key_arr   [ENTRIES];
  logic [ENTRIES-1:0]    valid_q, valid_d;
  logic [IW-1:0]         rec_q     [ENTRIES];
  logic [IW-1:0]         rec_d     [ENTRIES];
  logic [LW-1:0]         live_q, live_d;
  logic [CAP_BITS-1:0]   cap_q;

  // Value memory with a registered read port.
  logic [VALUE_BITS-1:0] val_mem   [ENTRIES];
  logic [VALUE_BITS-1:0] rd_data_q;

  // Lookup results carried into the apply cycle.
  logic [IW-1:0]         tgt_idx_q;
  logic [IW-1:0]         tgt_rank_q;
  logic                  hit_q;
  logic                  put_q;
  logic                  ins_q;
  logic                  upd_q;
  logic [KEY_BITS-1:0]   key_w_q;
  logic [VALUE_BITS-1:0] value_w_q;

  // Lookup logic.
  logic [KEY_BITS-1:0]   key_n;
  logic [ENTRIES-1:0]    match;
  logic [IW-1:0]         hit_idx;
  logic [IW-1:0]         hit_rank;
  logic                  hit;
  logic [CW-1:0]         eff_cap;
  logic                  has_room;
  logic [LW-1:0]         oldest_rank;
  logic [IW-1:0]         vic_idx;
  logic [IW-1:0]         free_idx;
  logic [IW-1:0]         tgt_idx;
  logic                  is_put;
  logic                  look_fire;
  logic                  apply_fire;

  logic                  out_valid_q;
  rsp_t                  rsp_q, rsp_d;

  assign look_fire  = (state_q == ST_LOOK) && chan_i.valid;
  assign apply_fire = (state_q == ST_APPLY);
  assign pop_o      = look_fire;
  assign is_put     = (chan_i.cmd.op == OP_PUT);
  assign key_n      = KEY_BITS'(chan_i.cmd.key);

  // Compare the key against every valid entry at once.
  always_comb begin
    hit_idx  = '0;
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (key_arr[i] == key_n);
      if (match[i]) begin
        hit_idx  = hit_idx | IW'(i);
        hit_rank = hit_rank | rec_q[i];
      end
    end
    hit = |match;
  end

  // Effective capacity: zero acts as one, values above the size clip.
  always_comb begin
    eff_cap = CW'(cap_q);
    if (eff_cap == '0) begin
      eff_cap = CW'(1);
    end
    if (eff_cap > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end
    has_room = CW'(live_q) < eff_cap;
  end

  // Ranks of live entries form 0..live-1 and entries fill from index zero,
  // so the victim holds rank live-1 and the next free slot is index live.
  always_comb begin
    oldest_rank = live_q - LW'(1);
    vic_idx     = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_q[i] && (rec_q[i] == IW'(oldest_rank))) begin
        vic_idx = vic_idx | IW'(i);
      end
    end
    free_idx = IW'(live_q);
  end

  // Pick the entry the command acts on.
  always_comb begin
    priority if (hit) begin
      tgt_idx = hit_idx;
    end else if (has_room) begin
      tgt_idx = free_idx;
    end else begin
      tgt_idx = vic_idx;
    end
  end

  // Sequencer: a lookup state, then an apply state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOOK: begin
        if (chan_i.valid) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_d = ST_LOOK;
      end
      default: begin
        state_d = ST_LOOK;
      end
    endcase
  end

  // Recency, valid and fill count updates for the apply cycle.
  always_comb begin
    valid_d = valid_q;
    live_d  = live_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rec_d[i] = rec_q[i];
    end
    if (apply_fire && upd_q) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IW'(i) == tgt_idx_q) begin
          rec_d[i] = '0;
        end else if (valid_q[i] && (!hit_q || (rec_q[i] < tgt_rank_q))) begin
          rec_d[i] = rec_q[i] + 1'b1;
        end
      end
    end
    if (apply_fire && ins_q) begin
      valid_d[tgt_idx_q] = 1'b1;
      live_d             = live_q + 1'b1;
    end
  end

  // Result of the command in the apply cycle.
  always_comb begin
    rsp_d.hit = hit_q;
    priority if (put_q) begin
      rsp_d.read_value = '0;
    end else if (hit_q) begin
      rsp_d.read_value = rd_data_q;
    end else begin
      rsp_d.read_value = MISS_VALUE;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOOK;
      valid_q     <= '0;
      live_q      <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rec_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      live_q      <= live_d;
      out_valid_q <= apply_fire;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      for (int i = 0; i < ENTRIES; i++) begin
        rec_q[i] <= rec_d[i];
      end
    end
  end

  // Payload registers captured during lookup and apply.
  always_ff @(posedge clk_i) begin
    if (look_fire) begin
      tgt_idx_q  <= tgt_idx;
      tgt_rank_q <= hit_rank;
      hit_q      <= hit;
      put_q      <= is_put;
      ins_q      <= is_put && !hit && has_room;
      upd_q      <= hit || is_put;
      key_w_q    <= key_n;
      value_w_q  <= chan_i.cmd.value;
    end
    if (apply_fire) begin
      rsp_q <= rsp_d;
    end
  end

  // Tag storage: written on an inserting or replacing put.
  always_ff @(posedge clk_i) begin
    if (apply_fire && put_q && !hit_q) begin
      key_arr[tgt_idx_q] <= key_w_q;
    end
  end

  // Value memory: read at the matched entry during lookup, written on a put.
  always_ff @(posedge clk_i) begin
    rd_data_q <= val_mem[hit_idx];
    if (apply_fire && put_q) begin
      val_mem[tgt_idx_q] <= value_w_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire
